// File: hw/rtl/pupm_pkg.sv
// Shared types and constants for the parity UART poll master.
// Depends on nothing; every other file of the block refers to it.
`timescale 1ns / 1ps

package pupm_pkg;

  localparam int unsigned REPLY_MAX_DEF      = 64;
  localparam int unsigned TEST_REPLY_MAX_DEF = 96;
  localparam int unsigned QUEUE_DEPTH_DEF    = 4;

  localparam int unsigned TICK_W   = 20;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned ADDR_W   = 5;

  localparam logic [TICK_W-1:0] TICK_MAX         = '1;
  localparam logic [TICK_W-1:0] TEST_CLOSE_DELAY = 20'd1000;

  // Register indexes
  localparam logic [2:0] REG_SETUP_HS_TO   = 3'd0;
  localparam logic [2:0] REG_REPLY_TO      = 3'd1;
  localparam logic [2:0] REG_BYTE_GAP      = 3'd2;
  localparam logic [2:0] REG_REQ_DELAY     = 3'd3;
  localparam logic [2:0] REG_POLL_DELAY    = 3'd4;
  localparam logic [2:0] REG_FINAL_DELAY   = 3'd5;
  localparam logic [2:0] REG_TEST_REPLY_TO = 3'd6;
  localparam logic [2:0] REG_TEST_GAP      = 3'd7;

  localparam logic [TICK_W-1:0] REG_RESET [NUM_REGS] = '{
    20'd5000, 20'd15000, 20'd2000, 20'd1400, 20'd1800, 20'd120, 20'd100000, 20'd4000
  };

  // Input commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_RX    = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Modes
  localparam logic [1:0] MODE_TEST  = 2'd0;
  localparam logic [1:0] MODE_SETUP = 2'd1;
  localparam logic [1:0] MODE_POLL  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_HS_TO     = 3'd1;
  localparam logic [2:0] ST_HS_BAD    = 3'd2;
  localparam logic [2:0] ST_ACK_TO    = 3'd3;
  localparam logic [2:0] ST_ACK_BAD   = 3'd4;
  localparam logic [2:0] ST_REPLY_TO  = 3'd5;
  localparam logic [2:0] ST_SHORT     = 3'd6;
  localparam logic [2:0] ST_LONG      = 3'd7;

  // Protocol bytes
  localparam logic [7:0] BYTE_WAKE    = 8'hC0;
  localparam logic [7:0] BYTE_ACK     = 8'h7F;
  localparam logic [7:0] BYTE_POLL    = 8'h20;
  localparam logic [7:0] BYTE_HS_OK   = 8'h00;
  localparam logic [7:0] REQ_B0       = 8'h00;
  localparam logic [7:0] REQ_B1       = 8'h04;
  localparam logic [7:0] REQ_B2       = 8'hC8;
  localparam logic [7:0] REQ_B4       = 8'hFF;
  localparam logic [7:0] REQ_SUM_BASE = 8'hCA; // low byte of 04+C8+FF+FF
  localparam logic [7:0] POLL_LEN     = 8'd13;

  localparam logic [2:0] REQ_LAST_BEAT = 3'd6;

  typedef enum logic [2:0] {
    JOB_TX    = 3'd0,
    JOB_DATA  = 3'd1,
    JOB_DONE  = 3'd2,
    JOB_REQ   = 3'd3,
    JOB_CLOSE = 3'd4
  } job_op_e;

  // One unit of work from the front end; the back end turns it into beats.
  typedef struct packed {
    job_op_e     op;
    logic [7:0]  byte_val;
    logic        par;
    logic [6:0]  idx;
    logic [2:0]  status;
    logic [15:0] volt;
    logic [15:0] curr;
  } job_t;

  typedef struct packed {
    logic [TICK_W-1:0] setup_hs_to;
    logic [TICK_W-1:0] reply_to;
    logic [TICK_W-1:0] byte_gap;
    logic [TICK_W-1:0] req_delay;
    logic [TICK_W-1:0] poll_delay;
    logic [TICK_W-1:0] final_delay;
    logic [TICK_W-1:0] test_reply_to;
    logic [TICK_W-1:0] test_gap;
  } cfg_t;

endpackage

// File: hw/rtl/parity_uart_poll_master.sv
// Top level of the parity UART poll master: config registers, front, queue, back.
// Depends on pupm_pkg, pupm_front, pupm_queue and pupm_back.
`timescale 1ns / 1ps

// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+------------------------------------------
// in       | in  | in_valid_i/in_ready_o  | cmd, mode, request_code, rx_byte, parity
// out      | out | out_valid_o/out_ready_i| kind, tx/data bytes, index, status, V, I
// cfg      | in  | APB psel/penable       | eight 20-bit tick registers at 4*i
//
// Each input beat is taken on a handshake; the front updates the sequence state
// and queues at most one job. The back end drains one result beat per cycle unless
// the output stalls; a request job yields seven beats and a closing job two.
// in_ready_o drops only while the job queue is full; reset empties the queue,
// idles the sequence and loads the register defaults. A stalled output
// register never blocks the front until the queue fills.

module parity_uart_poll_master #(
  parameter int unsigned REPLY_MAX      = pupm_pkg::REPLY_MAX_DEF,
  parameter int unsigned TEST_REPLY_MAX = pupm_pkg::TEST_REPLY_MAX_DEF,
  parameter int unsigned QUEUE_DEPTH    = pupm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pupm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  cmd_i,
  input  logic [1:0]                  mode_i,
  input  logic [7:0]                  request_code_i,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        rx_parity_mark_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  kind_o,
  output logic [7:0]                  tx_byte_o,
  output logic                        tx_parity_mark_o,
  output logic [7:0]                  data_byte_o,
  output logic [6:0]                  data_index_o,
  output logic [2:0]                  status_o,
  output logic [15:0]                 voltage_centi_o,
  output logic [15:0]                 current_centi_o,
  output logic                        last_o
);

  logic [pupm_pkg::TICK_W-1:0] reg_q [pupm_pkg::NUM_REGS];
  logic [2:0]                  reg_idx;
  logic                        cfg_wr, q_full, q_empty, push, pop, take;
  pupm_pkg::cfg_t              cfg;
  pupm_pkg::job_t              push_job, head_job;

  // Register file: write on the APB access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[pupm_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = 32'(reg_q[reg_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q <= pupm_pkg::REG_RESET;
    end else if (cfg_wr) begin
      reg_q[reg_idx] <= pwdata[pupm_pkg::TICK_W-1:0];
    end
  end

  assign cfg.setup_hs_to   = reg_q[pupm_pkg::REG_SETUP_HS_TO];
  assign cfg.reply_to      = reg_q[pupm_pkg::REG_REPLY_TO];
  assign cfg.byte_gap      = reg_q[pupm_pkg::REG_BYTE_GAP];
  assign cfg.req_delay     = reg_q[pupm_pkg::REG_REQ_DELAY];
  assign cfg.poll_delay    = reg_q[pupm_pkg::REG_POLL_DELAY];
  assign cfg.final_delay   = reg_q[pupm_pkg::REG_FINAL_DELAY];
  assign cfg.test_reply_to = reg_q[pupm_pkg::REG_TEST_REPLY_TO];
  assign cfg.test_gap      = reg_q[pupm_pkg::REG_TEST_GAP];

  // Hold the input while the queue has no room for a job
  assign in_ready_o = !q_full;
  assign take       = in_valid_i && in_ready_o;

  pupm_front #(
    .REPLY_MAX      (REPLY_MAX),
    .TEST_REPLY_MAX (TEST_REPLY_MAX)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .take_i           (take),
    .cmd_i            (cmd_i),
    .mode_i           (mode_i),
    .request_code_i   (request_code_i),
    .rx_byte_i        (rx_byte_i),
    .rx_parity_mark_i (rx_parity_mark_i),
    .push_o           (push),
    .job_o            (push_job)
  );

  pupm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  pupm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_job),
    .empty_i          (q_empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .tx_byte_o        (tx_byte_o),
    .tx_parity_mark_o (tx_parity_mark_o),
    .data_byte_o      (data_byte_o),
    .data_index_o     (data_index_o),
    .status_o         (status_o),
    .voltage_centi_o  (voltage_centi_o),
    .current_centi_o  (current_centi_o),
    .last_o           (last_o)
  );

  // A job only comes from an accepted beat, and never into a full queue
  a_push_only_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (take && !q_full)) else $error("job pushed without an accepted beat");

  // A finished beat always closes its input's results
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == pupm_pkg::KIND_DONE) |-> last_o)
    else $error("finish beat not marked last");

  // Captured bytes carry no status or measurement
  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == pupm_pkg::KIND_DATA) |->
      (status_o == pupm_pkg::ST_OK && voltage_centi_o == 16'd0))
    else $error("captured byte carries stray fields");

  // Pop only when a job is present
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty) else $error("pop from empty job queue");

endmodule

// File: hw/rtl/pupm_queue.sv
// Small job queue between the front and back ends of the poll master.
// Depends on pupm_pkg for the job type.
`timescale 1ns / 1ps

module pupm_queue #(
  parameter int unsigned DEPTH = pupm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pupm_pkg::job_t push_job_i,
  input  logic           pop_i,
  output pupm_pkg::job_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pupm_pkg::job_t    mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// File: hw/rtl/pupm_front.sv
// Front end: accepts commands, runs the exchange state machine and queues jobs.
// Depends on pupm_pkg.
`timescale 1ns / 1ps

module pupm_front #(
  parameter int unsigned REPLY_MAX      = pupm_pkg::REPLY_MAX_DEF,
  parameter int unsigned TEST_REPLY_MAX = pupm_pkg::TEST_REPLY_MAX_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pupm_pkg::cfg_t cfg_i,
  input  logic           take_i,
  input  logic [1:0]     cmd_i,
  input  logic [1:0]     mode_i,
  input  logic [7:0]     request_code_i,
  input  logic [7:0]     rx_byte_i,
  input  logic           rx_parity_mark_i,
  output logic           push_o,
  output pupm_pkg::job_t job_o
);

  typedef enum logic [7:0] {
    PH_IDLE        = 8'b0000_0001,
    PH_HS_WAIT     = 8'b0000_0010,
    PH_REQ_DELAY   = 8'b0000_0100,
    PH_ACK_WAIT    = 8'b0000_1000,
    PH_POLL_DELAY  = 8'b0001_0000,
    PH_FIRST_WAIT  = 8'b0010_0000,
    PH_COLLECT     = 8'b0100_0000,
    PH_FINAL_DELAY = 8'b1000_0000
  } phase_e;

  localparam logic [7:0] LIM_MAIN = 8'(REPLY_MAX);
  localparam logic [7:0] LIM_TEST = 8'(TEST_REPLY_MAX);

  phase_e                      phase_q, phase_d;
  logic [1:0]                  mode_q, mode_d;
  logic [7:0]                  code_q, code_d;
  logic [pupm_pkg::TICK_W-1:0] el_q, el_d, el_inc, thr;
  logic [7:0]                  cnt_q, cnt_d, cnt_inc;
  logic [15:0]                 volt_q, volt_d, curr_q, curr_d;
  logic                        is_test, is_poll, reached;
  logic [2:0]                  close_st;

  assign is_test = (mode_q == pupm_pkg::MODE_TEST);
  assign is_poll = (mode_q == pupm_pkg::MODE_POLL);
  assign el_inc  = (el_q == pupm_pkg::TICK_MAX) ? el_q : el_q + 1'b1;
  assign cnt_inc = cnt_q + 1'b1;

  // Threshold for the current wait
  always_comb begin
    case (phase_q)
      PH_HS_WAIT:     thr = (mode_q == pupm_pkg::MODE_SETUP) ? cfg_i.setup_hs_to
                                                             : cfg_i.reply_to;
      PH_REQ_DELAY:   thr = cfg_i.req_delay;
      PH_ACK_WAIT:    thr = cfg_i.reply_to;
      PH_POLL_DELAY:  thr = cfg_i.poll_delay;
      PH_FIRST_WAIT:  thr = is_test ? cfg_i.test_reply_to : cfg_i.reply_to;
      PH_COLLECT:     thr = is_test ? cfg_i.test_gap : cfg_i.byte_gap;
      PH_FINAL_DELAY: thr = is_test ? pupm_pkg::TEST_CLOSE_DELAY : cfg_i.final_delay;
      default:        thr = '0;
    endcase
  end
  assign reached = (el_inc >= thr);

  always_comb begin
    close_st = pupm_pkg::ST_OK;
    if (mode_q == pupm_pkg::MODE_SETUP && cnt_q > 8'd1) begin
      close_st = pupm_pkg::ST_LONG;
    end
    if (is_poll) begin
      if (cnt_q < pupm_pkg::POLL_LEN) begin
        close_st = pupm_pkg::ST_SHORT;
      end else if (cnt_q > pupm_pkg::POLL_LEN) begin
        close_st = pupm_pkg::ST_LONG;
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    mode_d  = mode_q;
    code_d  = code_q;
    el_d    = el_q;
    cnt_d   = cnt_q;
    volt_d  = volt_q;
    curr_d  = curr_q;
    push_o  = 1'b0;
    job_o   = '0;
    if (take_i) begin
      case (cmd_i)
        pupm_pkg::CMD_START: begin
          if (phase_q == PH_IDLE && mode_i != 2'd3) begin
            mode_d       = mode_i;
            code_d       = request_code_i;
            el_d         = '0;
            cnt_d        = '0;
            volt_d       = '0;
            curr_d       = '0;
            push_o       = 1'b1;
            job_o.op     = pupm_pkg::JOB_TX;
            job_o.par    = 1'b1;
            if (mode_i == pupm_pkg::MODE_TEST) begin
              phase_d        = PH_FIRST_WAIT;
              job_o.byte_val = request_code_i;
            end else begin
              phase_d        = PH_HS_WAIT;
              job_o.byte_val = pupm_pkg::BYTE_WAKE;
            end
          end
        end
        pupm_pkg::CMD_RX: begin
          case (phase_q)
            PH_HS_WAIT: begin
              el_d = '0;
              if (rx_byte_i != pupm_pkg::BYTE_HS_OK || rx_parity_mark_i) begin
                phase_d      = PH_IDLE;
                push_o       = 1'b1;
                job_o.op     = pupm_pkg::JOB_DONE;
                job_o.status = pupm_pkg::ST_HS_BAD;
              end else begin
                phase_d = PH_REQ_DELAY;
              end
            end
            PH_ACK_WAIT: begin
              el_d = '0;
              if (rx_byte_i != pupm_pkg::BYTE_ACK || rx_parity_mark_i) begin
                phase_d      = PH_IDLE;
                push_o       = 1'b1;
                job_o.op     = pupm_pkg::JOB_DONE;
                job_o.status = pupm_pkg::ST_ACK_BAD;
              end else begin
                phase_d = PH_POLL_DELAY;
              end
            end
            PH_FIRST_WAIT, PH_COLLECT: begin
              push_o         = 1'b1;
              job_o.op       = pupm_pkg::JOB_DATA;
              job_o.byte_val = rx_byte_i;
              job_o.idx      = cnt_q[6:0];
              if (is_poll) begin
                if (cnt_q == 8'd8)  volt_d[15:8] = rx_byte_i;
                if (cnt_q == 8'd9)  volt_d[7:0]  = rx_byte_i;
                if (cnt_q == 8'd10) curr_d[15:8] = rx_byte_i;
                if (cnt_q == 8'd11) curr_d[7:0]  = rx_byte_i;
              end
              cnt_d   = cnt_inc;
              el_d    = '0;
              phase_d = (cnt_inc >= (is_test ? LIM_TEST : LIM_MAIN)) ? PH_FINAL_DELAY
                                                                     : PH_COLLECT;
            end
            default: begin
            end
          endcase
        end
        pupm_pkg::CMD_TICK: begin
          if (phase_q != PH_IDLE) begin
            el_d = el_inc;
            if (reached) begin
              el_d = '0;
              case (phase_q)
                PH_HS_WAIT: begin
                  phase_d      = PH_IDLE;
                  push_o       = 1'b1;
                  job_o.op     = pupm_pkg::JOB_DONE;
                  job_o.status = pupm_pkg::ST_HS_TO;
                end
                PH_REQ_DELAY: begin
                  phase_d        = PH_ACK_WAIT;
                  push_o         = 1'b1;
                  job_o.op       = pupm_pkg::JOB_REQ;
                  job_o.byte_val = code_q;
                end
                PH_ACK_WAIT: begin
                  phase_d      = PH_IDLE;
                  push_o       = 1'b1;
                  job_o.op     = pupm_pkg::JOB_DONE;
                  job_o.status = pupm_pkg::ST_ACK_TO;
                end
                PH_POLL_DELAY: begin
                  phase_d        = PH_FIRST_WAIT;
                  push_o         = 1'b1;
                  job_o.op       = pupm_pkg::JOB_TX;
                  job_o.byte_val = pupm_pkg::BYTE_POLL;
                  job_o.par      = 1'b1;
                end
                PH_FIRST_WAIT: begin
                  phase_d      = PH_IDLE;
                  push_o       = 1'b1;
                  job_o.op     = pupm_pkg::JOB_DONE;
                  job_o.status = pupm_pkg::ST_REPLY_TO;
                end
                PH_COLLECT: begin
                  phase_d = PH_FINAL_DELAY;
                end
                PH_FINAL_DELAY: begin
                  phase_d      = PH_IDLE;
                  push_o       = 1'b1;
                  job_o.op     = pupm_pkg::JOB_CLOSE;
                  job_o.status = close_st;
                  if (is_poll && close_st == pupm_pkg::ST_OK) begin
                    job_o.volt = volt_q;
                    job_o.curr = curr_q;
                  end
                end
                default: begin
                  phase_d = PH_IDLE;
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      mode_q  <= '0;
      code_q  <= '0;
      el_q    <= '0;
      cnt_q   <= '0;
      volt_q  <= '0;
      curr_q  <= '0;
    end else begin
      phase_q <= phase_d;
      mode_q  <= mode_d;
      code_q  <= code_d;
      el_q    <= el_d;
      cnt_q   <= cnt_d;
      volt_q  <= volt_d;
      curr_q  <= curr_d;
    end
  end

endmodule

// File: hw/rtl/pupm_back.sv
// Back end: expands queued jobs into result beats behind an output register.
// Depends on pupm_pkg.
`timescale 1ns / 1ps

module pupm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pupm_pkg::job_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     kind_o,
  output logic [7:0]     tx_byte_o,
  output logic           tx_parity_mark_o,
  output logic [7:0]     data_byte_o,
  output logic [6:0]     data_index_o,
  output logic [2:0]     status_o,
  output logic [15:0]    voltage_centi_o,
  output logic [15:0]    current_centi_o,
  output logic           last_o
);

  logic [2:0]  beat_q, beat_d;
  logic        valid_q, valid_d, load, beat_last;
  logic [1:0]  kind_n;
  logic [7:0]  tx_n, data_n;
  logic        par_n;
  logic [6:0]  idx_n;
  logic [2:0]  st_n;
  logic [15:0] v_n, c_n;
  logic [1:0]  kind_q;
  logic [7:0]  tx_q, data_q;
  logic        par_q, last_q;
  logic [6:0]  idx_q;
  logic [2:0]  st_q;
  logic [15:0] v_q, c_q;

  assign load = !empty_i && (!valid_q || out_ready_i);

  // Build the beat selected by the beat counter
  always_comb begin
    kind_n    = pupm_pkg::KIND_TX;
    tx_n      = '0;
    par_n     = 1'b0;
    data_n    = '0;
    idx_n     = '0;
    st_n      = '0;
    v_n       = '0;
    c_n       = '0;
    beat_last = 1'b1;
    case (head_i.op)
      pupm_pkg::JOB_TX: begin
        tx_n  = head_i.byte_val;
        par_n = head_i.par;
      end
      pupm_pkg::JOB_DATA: begin
        kind_n = pupm_pkg::KIND_DATA;
        data_n = head_i.byte_val;
        idx_n  = head_i.idx;
      end
      pupm_pkg::JOB_DONE: begin
        kind_n = pupm_pkg::KIND_DONE;
        st_n   = head_i.status;
      end
      pupm_pkg::JOB_REQ: begin
        beat_last = (beat_q == pupm_pkg::REQ_LAST_BEAT);
        case (beat_q)
          3'd0:    tx_n = pupm_pkg::REQ_B0;
          3'd1:    tx_n = pupm_pkg::REQ_B1;
          3'd2:    tx_n = pupm_pkg::REQ_B2;
          3'd3:    tx_n = head_i.byte_val;
          3'd4:    tx_n = pupm_pkg::REQ_B4;
          3'd5:    tx_n = pupm_pkg::REQ_B4;
          default: tx_n = head_i.byte_val + pupm_pkg::REQ_SUM_BASE;
        endcase
      end
      pupm_pkg::JOB_CLOSE: begin
        if (beat_q == 3'd0) begin
          beat_last = 1'b0;
          tx_n      = pupm_pkg::BYTE_ACK;
        end else begin
          kind_n = pupm_pkg::KIND_DONE;
          st_n   = head_i.status;
          v_n    = head_i.volt;
          c_n    = head_i.curr;
        end
      end
      default: begin
      end
    endcase
  end

  assign pop_o = load && beat_last;

  always_comb begin
    beat_d  = beat_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      beat_d  = beat_last ? 3'd0 : beat_q + 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      beat_q  <= beat_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_n;
      tx_q   <= tx_n;
      par_q  <= par_n;
      data_q <= data_n;
      idx_q  <= idx_n;
      st_q   <= st_n;
      v_q    <= v_n;
      c_q    <= c_n;
      last_q <= beat_last;
    end
  end

  assign out_valid_o      = valid_q;
  assign kind_o           = kind_q;
  assign tx_byte_o        = tx_q;
  assign tx_parity_mark_o = par_q;
  assign data_byte_o      = data_q;
  assign data_index_o     = idx_q;
  assign status_o         = st_q;
  assign voltage_centi_o  = v_q;
  assign current_centi_o  = c_q;
  assign last_o           = last_q;

endmodule
